@@ hdl/flc_pkg.sv @@
// shared constants and types for the full linear convolution block
package flc_pkg;

    localparam int MAX_TAPS  = 16;
    localparam int DATA_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
    // product stage plus one psum hop per cell
    localparam int SETTLE    = MAX_TAPS + 1;
    localparam int SETTLE_W  = $clog2(SETTLE + 1);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

@@ hdl/flc_cell.sv @@
// one tap cell: tap register, delay stage, product register and partial sum stage
module flc_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  flc_pkg::cell_ctrl_t                  ctrl,
    input  logic                                 tap_we,
    input  logic signed [flc_pkg::DATA_W-1:0]    tap_val,
    input  logic                                 tap_en,
    input  logic signed [flc_pkg::DATA_W-1:0]    delay_in,
    output logic signed [flc_pkg::DATA_W-1:0]    delay_out,
    input  logic        [flc_pkg::DATA_W-1:0]    psum_in,
    output logic        [flc_pkg::DATA_W-1:0]    psum_out
);

    logic signed [flc_pkg::DATA_W-1:0] tap_reg;
    logic signed [flc_pkg::DATA_W-1:0] delay_reg;
    logic        [flc_pkg::DATA_W-1:0] prod_reg;
    logic        [flc_pkg::DATA_W-1:0] prod_next;
    logic        [flc_pkg::DATA_W-1:0] psum_reg;
    logic        [flc_pkg::DATA_W-1:0] psum_next;
    logic signed [flc_pkg::PROD_W-1:0] prod_full;

    always_comb begin
        prod_full = tap_reg * delay_reg;
        // only the low bits matter since the sum wraps
        prod_next = tap_en ? prod_full[flc_pkg::DATA_W-1:0] : '0;
        psum_next = psum_in + prod_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
        end else if (ctrl.clear) begin
            delay_reg <= '0;
        end else if (ctrl.shift) begin
            delay_reg <= delay_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (tap_we) begin
            tap_reg <= tap_val;
        end
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign delay_out = delay_reg;
    assign psum_out  = psum_reg;

endmodule

@@ hdl/full_linear_convolution.sv @@
// full linear convolution top level: control sequencer and row of tap cells
//
// input channel (s_valid/s_ready): s_opcode selects a tap load or a sample,
// s_value carries the signed 16-bit value, s_last closes a tap set or ends
// a sample sequence. a load beat gives no result. a sample beat shifts
// into the cell row; its output appears on m_result once the products
// are registered and the partial sum has rippled through the row, one
// cell per cycle. a last sample then flushes tap count minus one more
// outputs with zeros shifted in; m_final_res marks the last output and
// the delay line is cleared after it.
// s_ready drops after a sample beat and stays low until its output (and
// any tail flush) has gone into the output register, so a new beat is
// taken only once the last sample is through.
// the output register holds one result; if the receiver stalls, the next
// result waits in the cell row and the block takes no further beat.
// reset clears the delay line, the tap count and the output valid, and
// leaves the tap set closed so the next load starts a new set.
module full_linear_convolution (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic signed [flc_pkg::DATA_W-1:0]    s_value,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [flc_pkg::DATA_W-1:0]    m_result,
    output logic                                 m_final_res
);

    typedef enum logic {
        IDLE,
        CALC
    } state_t;

    state_t                              state_reg, state_next;
    logic [flc_pkg::SETTLE_W-1:0]        cnt_reg, cnt_next;
    logic [flc_pkg::TAP_CNT_W-1:0]       tap_count_reg, tap_count_next;
    logic                                taps_closed_reg, taps_closed_next;
    logic [flc_pkg::TAP_CNT_W-1:0]       tail_reg, tail_next;
    logic                                last_reg, last_next;
    logic                                m_valid_reg, m_valid_next;
    logic [flc_pkg::DATA_W-1:0]          result_reg, result_next;
    logic                                final_reg, final_next;

    logic                                in_beat;
    logic                                load_beat;
    logic                                sample_beat;
    logic                                out_load;
    logic [flc_pkg::TAP_CNT_W-1:0]       wr_idx;
    logic                                wr_ok;
    logic                                shift_zero;
    flc_pkg::cell_ctrl_t                 cell_ctrl;
    logic signed [flc_pkg::DATA_W-1:0]   row_in;

    logic signed [flc_pkg::DATA_W-1:0]   delay_chain [flc_pkg::MAX_TAPS];
    logic        [flc_pkg::DATA_W-1:0]   psum_chain  [flc_pkg::MAX_TAPS];
    logic        [flc_pkg::MAX_TAPS-1:0] tap_we;
    logic        [flc_pkg::MAX_TAPS-1:0] tap_en;

    assign in_beat     = s_valid && s_ready;
    assign load_beat   = in_beat && (s_opcode == flc_pkg::OP_LOAD);
    assign sample_beat = in_beat && (s_opcode == flc_pkg::OP_SAMPLE);
    assign out_load    = (state_reg == CALC)
                         && (cnt_reg == flc_pkg::SETTLE_W'(flc_pkg::SETTLE))
                         && (!m_valid_reg || m_ready);
    // a closed set restarts at index zero
    assign wr_idx      = taps_closed_reg ? '0 : tap_count_reg;
    assign wr_ok       = wr_idx < flc_pkg::TAP_CNT_W'(flc_pkg::MAX_TAPS);
    assign shift_zero  = out_load && (tail_reg != '0);

    always_comb begin
        cell_ctrl.shift = sample_beat || shift_zero;
        cell_ctrl.clear = out_load && (tail_reg == '0) && last_reg;
        row_in          = shift_zero ? '0 : s_value;
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        tap_count_next   = tap_count_reg;
        taps_closed_next = taps_closed_reg;
        tail_next        = tail_reg;
        last_next        = last_reg;
        m_valid_next     = m_valid_reg;
        result_next      = result_reg;
        final_next       = final_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE: begin
                if (load_beat) begin
                    tap_count_next   = wr_ok ? wr_idx + 1'b1 : wr_idx;
                    taps_closed_next = s_last;
                end else if (sample_beat) begin
                    tail_next  = (s_last && tap_count_reg > 1)
                                 ? tap_count_reg - 1'b1 : '0;
                    last_next  = s_last;
                    cnt_next   = '0;
                    state_next = CALC;
                end
            end
            CALC: begin
                if (cnt_reg != flc_pkg::SETTLE_W'(flc_pkg::SETTLE)) begin
                    cnt_next = cnt_reg + 1'b1;
                end else if (out_load) begin
                    m_valid_next = 1'b1;
                    result_next  = psum_chain[flc_pkg::MAX_TAPS-1];
                    final_next   = last_reg && (tail_reg == '0);
                    if (tail_reg != '0) begin
                        tail_next = tail_reg - 1'b1;
                        cnt_next  = '0;
                    end else begin
                        state_next = IDLE;
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= IDLE;
            cnt_reg         <= '0;
            tap_count_reg   <= '0;
            taps_closed_reg <= 1'b1;
            tail_reg        <= '0;
            last_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            tap_count_reg   <= tap_count_next;
            taps_closed_reg <= taps_closed_next;
            tail_reg        <= tail_next;
            last_reg        <= last_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        final_reg  <= final_next;
    end

    genvar k;
    generate
        for (k = 0; k < flc_pkg::MAX_TAPS; k++) begin : g_cell
            assign tap_we[k] = load_beat && wr_ok
                               && (wr_idx == flc_pkg::TAP_CNT_W'(k));
            assign tap_en[k] = flc_pkg::TAP_CNT_W'(k) < tap_count_reg;

            if (k == 0) begin : g_head
                flc_cell u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl      (cell_ctrl),
                    .tap_we    (tap_we[k]),
                    .tap_val   (s_value),
                    .tap_en    (tap_en[k]),
                    .delay_in  (row_in),
                    .delay_out (delay_chain[k]),
                    .psum_in   ({flc_pkg::DATA_W{1'b0}}),
                    .psum_out  (psum_chain[k])
                );
            end else begin : g_body
                flc_cell u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .ctrl      (cell_ctrl),
                    .tap_we    (tap_we[k]),
                    .tap_val   (s_value),
                    .tap_en    (tap_en[k]),
                    .delay_in  (delay_chain[k-1]),
                    .delay_out (delay_chain[k]),
                    .psum_in   (psum_chain[k-1]),
                    .psum_out  (psum_chain[k])
                );
            end
        end
    endgenerate

    assign s_ready     = (state_reg == IDLE);
    assign m_valid     = m_valid_reg;
    assign m_result    = result_reg;
    assign m_final_res = final_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_count_reg <= flc_pkg::TAP_CNT_W'(flc_pkg::MAX_TAPS))
        else $error("tap count above tap row depth");

    a_load_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        load_beat |=> (state_reg == IDLE))
        else $error("tap load started a computation");

    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_beat |=> (state_reg == CALC) && (cnt_reg == '0))
        else $error("sample beat did not start a computation");

    a_valid_from_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == CALC))
        else $error("result presented without a computation");

    a_tail_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && tail_reg != '0) |=> !final_reg && (state_reg == CALC))
        else $error("tail output marked final too early");

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the full linear convolution block
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT      = 500000;
    localparam int DRAIN      = 4 * (flc_pkg::MAX_TAPS + 2);
    localparam int HOLD_LEN   = 400;
    localparam int N_ITEMS    = 320;

    typedef struct {
        logic                              op;
        logic signed [flc_pkg::DATA_W-1:0] value;
        logic                              last;
    } conv_beat_t;

    typedef struct {
        logic signed [flc_pkg::DATA_W-1:0] result;
        logic                              final_res;
    } conv_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = flc_pkg::OP_LOAD;
    logic signed [flc_pkg::DATA_W-1:0] s_value = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [flc_pkg::DATA_W-1:0] m_result;
    logic m_final_res;

    full_linear_convolution dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .m_final_res (m_final_res)
    );

    always #10 aclk = ~aclk;

    conv_beat_t pending[$];
    conv_out_t  conv_expect[$];

    // predictor state
    logic signed [flc_pkg::DATA_W-1:0] tap_mem [flc_pkg::MAX_TAPS];
    logic signed [flc_pkg::DATA_W-1:0] dline [flc_pkg::MAX_TAPS];
    int   tap_cnt = 0;
    bit   set_closed = 1'b1;

    int   beats_in = 0;
    int   mismatches = 0;
    int   cycles = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    // no idling on either side for a stretch of the run
    wire calm = (beats_in >= 150) && (beats_in < 230);
    wire hold_on = (hold_left != 0) || (!hold_done && beats_in >= 40);

    task automatic shift_line(input logic signed [flc_pkg::DATA_W-1:0] v);
        for (int k = flc_pkg::MAX_TAPS - 1; k > 0; k--)
            dline[k] = dline[k - 1];
        dline[0] = v;
    endtask

    function automatic logic signed [flc_pkg::DATA_W-1:0] tap_dot();
        int acc;
        acc = 0;
        for (int k = 0; k < tap_cnt; k++)
            acc = acc + int'(tap_mem[k]) * int'(dline[k]);
        return acc[flc_pkg::DATA_W-1:0];
    endfunction

    task automatic push_out(input logic signed [flc_pkg::DATA_W-1:0] r, input logic fin);
        conv_expect.push_back(conv_out_t'{r, fin});
    endtask

    task automatic convolve_item(input logic op, input logic signed [flc_pkg::DATA_W-1:0] v,
                                 input logic last);
        int tail;
        if (op == flc_pkg::OP_LOAD) begin
            if (set_closed) begin
                tap_cnt = 0;
                set_closed = 1'b0;
            end
            // a full set ignores the value but still honors the last mark
            if (tap_cnt < flc_pkg::MAX_TAPS) begin
                tap_mem[tap_cnt] = v;
                tap_cnt++;
            end
            if (last)
                set_closed = 1'b1;
        end else begin
            shift_line(v);
            tail = (last && tap_cnt > 1) ? tap_cnt - 1 : 0;
            push_out(tap_dot(), last && (tail == 0));
            for (int t = 0; t < tail; t++) begin
                shift_line('0);
                push_out(tap_dot(), (t + 1) == tail);
            end
            if (last) begin
                for (int k = 0; k < flc_pkg::MAX_TAPS; k++)
                    dline[k] = '0;
            end
        end
    endtask

    function automatic logic [flc_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return flc_pkg::DATA_W'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic op, input logic [flc_pkg::DATA_W-1:0] v,
                            input logic last);
        pending.push_back(conv_beat_t'{op, v, last});
    endtask

    // sender: holds each beat until accepted, idles at random otherwise
    always @(posedge aclk) begin : drive_proc
        conv_beat_t nxt;
        logic       give;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            give = s_valid;
            if (s_valid && s_ready) begin
                convolve_item(s_opcode, s_value, s_last);
                beats_in <= beats_in + 1;
                give = 1'b0;
            end
            if (!give && pending.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
                nxt = pending.pop_front();
                s_opcode <= nxt.op;
                s_value  <= nxt.value;
                s_last   <= nxt.last;
                give = 1'b1;
            end
            s_valid <= give;
        end
    end

    // one long hold-off so the block backs up and stalls its input
    always @(posedge aclk) begin : hold_proc
        if (aresetn) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (!hold_done && beats_in >= 40) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
            end
        end
    end

    // receiver: checks each result beat against the oldest expectation
    always @(posedge aclk) begin : recv_proc
        conv_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (conv_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d final %0b", m_result, m_final_res);
                end else begin
                    want = conv_expect.pop_front();
                    if (m_result !== want.result || m_final_res !== want.final_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d final %0b, got %0d final %0b",
                                     want.result, want.final_res, m_result, m_final_res);
                    end
                end
            end
            if (hold_on) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("full_linear_convolution verification failed");
            $finish;
        end
    end

    initial begin
        int n_taps;
        int n_samp;
        for (int k = 0; k < flc_pkg::MAX_TAPS; k++) begin
            tap_mem[k] = '0;
            dline[k] = '0;
        end

        // no taps yet: zero outputs, last sample ends with no tail
        add_item(flc_pkg::OP_SAMPLE, 16'h7FFF, 1'b0);
        add_item(flc_pkg::OP_SAMPLE, 16'h8000, 1'b1);
        // single tap at the extremes
        add_item(flc_pkg::OP_LOAD,   16'h8000, 1'b1);
        add_item(flc_pkg::OP_SAMPLE, 16'h8000, 1'b0);
        add_item(flc_pkg::OP_SAMPLE, 16'h7FFF, 1'b1);
        // samples while the set is open, then a new set mid-sequence
        add_item(flc_pkg::OP_LOAD,   16'h7FFF, 1'b0);
        add_item(flc_pkg::OP_SAMPLE, 16'hFFFF, 1'b0);
        add_item(flc_pkg::OP_LOAD,   16'h0001, 1'b1);
        add_item(flc_pkg::OP_LOAD,   16'h8000, 1'b0);
        add_item(flc_pkg::OP_SAMPLE, 16'h8000, 1'b1);
        // overfull set: loads past the row depth are dropped, the last still closes the set
        for (int i = 0; i <= flc_pkg::MAX_TAPS; i++)
            add_item(flc_pkg::OP_LOAD, i[0] ? 16'h7FFF : (16'h8000 ^ 16'(i)),
                     i == flc_pkg::MAX_TAPS);
        add_item(flc_pkg::OP_SAMPLE, 16'h7FFF, 1'b1);

        while (pending.size() < N_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
                add_item(1'($urandom), pick_value(), 1'($urandom));
            end else begin
                n_taps = ($urandom_range(0, 9) == 0)
                         ? $urandom_range(flc_pkg::MAX_TAPS, flc_pkg::MAX_TAPS + 2)
                         : $urandom_range(1, 5);
                n_samp = $urandom_range(1, 6);
                for (int i = 0; i < n_taps; i++)
                    add_item(flc_pkg::OP_LOAD, pick_value(), i == n_taps - 1);
                for (int i = 0; i < n_samp; i++)
                    add_item(flc_pkg::OP_SAMPLE, pick_value(), i == n_samp - 1);
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() > 0 || s_valid || conv_expect.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (mismatches == 0 && conv_expect.size() == 0) begin
            $display("full_linear_convolution verification clean");
        end else begin
            $display("full_linear_convolution verification failed");
        end
        $finish;
    end

endmodule
